@@ rtl/pul_pkg.sv @@
package pul_pkg;

  localparam int MAX_POINTS      = 64;
  localparam int NUM_SUBCARRIERS = 64;
  localparam int MIN_POINTS      = 3;

  localparam int IDX_W   = 6;
  localparam int PH_W    = 16;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int SLOPE_W = 19;
  localparam int ICPT_W  = 24;
  localparam int STAT_W  = 2;

  // Phase scale: Q3.13, so pi and one full turn in those units.
  localparam int PH_PI   = 25736;
  localparam int PH_TURN = 51472;

  localparam int TURN_W = 8;   // whole-turn count of the unwrapped phase
  localparam int Y_W    = 26;  // unwrapped phase
  localparam int SX_W   = 13;
  localparam int SXX_W  = 18;
  localparam int SY_W   = 34;
  localparam int SXY_W  = 40;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int DVD_W = 64;
  localparam int DVS_W = 32;
  localparam int DCNT_W = $clog2(DVD_W);

  typedef enum logic [STAT_W-1:0] {
    ST_FITTED = 2'd0,
    ST_FEW    = 2'd1,
    ST_DEGEN  = 2'd2
  } status_t;

  typedef struct packed {
    logic [IDX_W-1:0]       idx;
    logic signed [PH_W-1:0] phase;
    logic                   keep;
    logic                   last;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

@@ rtl/pul_div.sv @@
module pul_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pul_pkg::div_req_t         req,
  output logic                      done,
  output logic [pul_pkg::DVD_W-1:0] quotient
);
  import pul_pkg::*;

  logic [DVS_W:0]    rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  div_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [DVS_W:0]    shifted;
  logic              fits;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
  assign fits    = (shifted >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        quo_r <= req.dividend;
        div_r <= req.divisor;
      end else if (run_r) begin
        rem_r <= fits ? (shifted - {1'b0, div_r}) : shifted;
        quo_r <= {quo_r[DVD_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/pul_front.sv @@
module pul_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [pul_pkg::IDX_W-1:0]        in_subcarrier_index,
  input  logic signed [pul_pkg::PH_W-1:0]  in_phase_sample,
  input  logic                             in_sample_valid,
  input  logic                             in_last_sample,
  input  logic                             pop,
  output logic                             q_valid,
  output pul_pkg::item_t                   q_head
);
  import pul_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] head_r;
  logic [QPTR_W-1:0] tail_r;
  logic [QPTR_W:0]   fill_r;
  logic [CNT_W-1:0]  kept_r;
  logic              accept;
  logic              keep;
  item_t             item;

  assign busy   = (fill_r == (QPTR_W+1)'(QDEPTH));
  assign accept = start && !busy;

  // Kept: usable, in range, and the frame's point budget not yet spent.
  assign keep = in_sample_valid
             && ((IDX_W+3)'(in_subcarrier_index) < (IDX_W+3)'(NUM_SUBCARRIERS))
             && (kept_r < CNT_W'(MAX_POINTS));

  always_comb begin
    item.idx   = in_subcarrier_index;
    item.phase = in_phase_sample;
    item.keep  = keep;
    item.last  = in_last_sample;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[tail_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      kept_r <= '0;
    end else begin
      if (accept) begin
        tail_r <= tail_r + 1'b1;
        if (in_last_sample) begin
          kept_r <= '0;
        end else if (keep) begin
          kept_r <= kept_r + 1'b1;
        end
      end
      if (pop) begin
        head_r <= head_r + 1'b1;
      end
      if (accept && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !accept) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  assign q_valid = (fill_r != '0);
  assign q_head  = mem_r[head_r];

endmodule

@@ rtl/pul_back.sv @@
module pul_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  pul_pkg::item_t                    q_head,
  output logic                              pop,
  output pul_pkg::div_req_t                 div_req,
  input  logic                              div_done,
  input  logic [pul_pkg::DVD_W-1:0]         div_quo,
  output logic                              out_valid,
  output logic signed [pul_pkg::SLOPE_W-1:0] out_fit_slope,
  output logic signed [pul_pkg::ICPT_W-1:0] out_fit_intercept,
  output logic [pul_pkg::CNT_W-1:0]         out_points_used,
  output logic [pul_pkg::STAT_W-1:0]        out_fit_status
);
  import pul_pkg::*;

  localparam int E_W   = PH_W + 2;
  localparam int P1_W  = CNT_W + SXX_W;
  localparam int P2_W  = 2 * SX_W;
  localparam int DEN_W = P2_W + 1;
  localparam int Q_W   = SXY_W + CNT_W + 1;
  localparam int NUM_W = Q_W + 1;
  localparam int R_W   = 64;
  localparam int XY_W  = Y_W + IDX_W + 1;
  localparam logic [DVD_W-1:0] SLOPE_POS = DVD_W'((1 << (SLOPE_W - 1)) - 1);
  localparam logic [DVD_W-1:0] SLOPE_NEG = DVD_W'(1 << (SLOPE_W - 1));
  localparam logic [DVD_W-1:0] ICPT_POS  = DVD_W'((1 << (ICPT_W - 1)) - 1);
  localparam logic [DVD_W-1:0] ICPT_NEG  = DVD_W'(1 << (ICPT_W - 1));

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_DIVS, S_WAITS, S_DIVI, S_WAITI
  } state_t;

  state_t                    state_r;
  logic [CNT_W-1:0]          count_r;
  logic signed [TURN_W-1:0]  turns_r;
  logic signed [PH_W-1:0]    ph_prev_r;
  logic [SX_W-1:0]           sx_r;
  logic [SXX_W-1:0]          sxx_r;
  logic signed [SY_W-1:0]    sy_r;
  logic signed [SXY_W-1:0]   sxy_r;
  logic [IDX_W-1:0]          x_r;
  logic signed [Y_W-1:0]     y_r;
  logic                      keep_r;
  logic                      last_r;
  logic                      degen_r;
  logic [P1_W-1:0]           p1_r;
  logic [P2_W-1:0]           p2_r;
  logic signed [DEN_W-1:0]   den_r;
  logic signed [Q_W-1:0]     q1_r;
  logic signed [Q_W-1:0]     q2_r;
  logic signed [NUM_W-1:0]   num_r;
  logic signed [R_W-1:0]     r1_r;
  logic signed [R_W-1:0]     r2_r;
  logic signed [R_W-1:0]     inum_r;
  logic [DVS_W-1:0]          nd_r;
  logic signed [SLOPE_W-1:0] slope_r;
  logic                      out_valid_r;
  logic signed [SLOPE_W-1:0] slope_out_r;
  logic signed [ICPT_W-1:0]  icpt_out_r;
  logic [CNT_W-1:0]          pts_out_r;
  logic [STAT_W-1:0]         stat_out_r;

  logic signed [E_W-1:0]     e;
  logic signed [TURN_W-1:0]  dk;
  logic signed [TURN_W-1:0]  k_new;
  logic signed [Y_W-1:0]     y_new;
  logic signed [XY_W-1:0]    xy;
  logic signed [NUM_W-1:0]   num_abs;
  logic signed [R_W-1:0]     inum_abs;
  logic signed [SY_W-1:0]    sy_abs;

  function automatic logic signed [SLOPE_W-1:0] sat_slope(input logic neg,
                                                          input logic [DVD_W-1:0] q);
    logic signed [SLOPE_W-1:0] r;
    if (!neg) begin
      r = (q > SLOPE_POS) ? SLOPE_W'(SLOPE_POS) : SLOPE_W'(q);
    end else begin
      r = (q > SLOPE_NEG) ? SLOPE_W'(SLOPE_NEG) : -SLOPE_W'(q);
    end
    return r;
  endfunction

  function automatic logic signed [ICPT_W-1:0] sat_icpt(input logic neg,
                                                        input logic [DVD_W-1:0] q);
    logic signed [ICPT_W-1:0] r;
    if (!neg) begin
      r = (q > ICPT_POS) ? ICPT_W'(ICPT_POS) : ICPT_W'(q);
    end else begin
      r = (q > ICPT_NEG) ? ICPT_W'(ICPT_NEG) : -ICPT_W'(q);
    end
    return r;
  endfunction

  // The unwrapped phase is the raw phase minus whole turns. Between two kept
  // points the turn count moves by at most one, decided by two compares.
  always_comb begin
    e = E_W'(q_head.phase) - E_W'(ph_prev_r) - E_W'(PH_PI);
    if (e > 0) begin
      dk = TURN_W'(1);
    end else if (e <= -E_W'(PH_TURN)) begin
      dk = -TURN_W'(1);
    end else begin
      dk = '0;
    end
    k_new = (count_r == '0) ? '0 : (turns_r + dk);
    y_new = Y_W'(q_head.phase) - Y_W'(k_new * $signed(18'(PH_TURN)));
    xy    = XY_W'($signed({1'b0, x_r})) * XY_W'(y_r);
    num_abs  = num_r[NUM_W-1] ? -num_r : num_r;
    inum_abs = inum_r[R_W-1] ? -inum_r : inum_r;
    sy_abs   = sy_r[SY_W-1] ? -sy_r : sy_r;
  end

  assign pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    div_req.start = (state_r == S_DIVS) || (state_r == S_DIVI);
    if (state_r == S_DIVS) begin
      div_req.dividend = DVD_W'({num_abs[NUM_W-2:0], 3'b000})
                       + DVD_W'(den_r[DEN_W-2:1]);
      div_req.divisor  = DVS_W'(den_r[DEN_W-2:0]);
    end else if (degen_r) begin
      div_req.dividend = DVD_W'(sy_abs[SY_W-2:0]) + DVD_W'(count_r[CNT_W-1:1]);
      div_req.divisor  = DVS_W'(count_r);
    end else begin
      div_req.dividend = DVD_W'(inum_abs[R_W-2:0]) + DVD_W'(nd_r[DVS_W-1:1]);
      div_req.divisor  = nd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      turns_r     <= '0;
      ph_prev_r   <= '0;
      sx_r        <= '0;
      sxx_r       <= '0;
      sy_r        <= '0;
      sxy_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            x_r    <= q_head.idx;
            y_r    <= y_new;
            keep_r <= q_head.keep;
            last_r <= q_head.last;
            if (q_head.keep) begin
              ph_prev_r <= q_head.phase;
              turns_r   <= k_new;
              count_r   <= count_r + 1'b1;
            end
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (keep_r) begin
            sx_r  <= sx_r + SX_W'(x_r);
            sxx_r <= sxx_r + SXX_W'(SXX_W'(x_r) * SXX_W'(x_r));
            sy_r  <= sy_r + SY_W'(y_r);
            sxy_r <= sxy_r + SXY_W'(xy);
          end
          state_r <= last_r ? S_M0 : S_IDLE;
        end
        S_M0: begin
          p1_r    <= P1_W'(count_r) * P1_W'(sxx_r);
          p2_r    <= P2_W'(sx_r) * P2_W'(sx_r);
          state_r <= S_M1;
        end
        S_M1: begin
          den_r   <= $signed({2'b00, p1_r}) - $signed({1'b0, p2_r});
          q1_r    <= Q_W'(sxy_r) * Q_W'($signed({1'b0, count_r}));
          q2_r    <= Q_W'(sy_r) * Q_W'($signed({1'b0, sx_r}));
          state_r <= S_M2;
        end
        S_M2: begin
          num_r <= NUM_W'(q1_r) - NUM_W'(q2_r);
          if (count_r < CNT_W'(MIN_POINTS)) begin
            slope_out_r <= '0;
            icpt_out_r  <= '0;
            pts_out_r   <= count_r;
            stat_out_r  <= ST_FEW;
            out_valid_r <= 1'b1;
            count_r     <= '0;
            turns_r     <= '0;
            ph_prev_r   <= '0;
            sx_r        <= '0;
            sxx_r       <= '0;
            sy_r        <= '0;
            sxy_r       <= '0;
            state_r     <= S_IDLE;
          end else if (den_r <= 0) begin
            degen_r <= 1'b1;
            slope_r <= '0;
            state_r <= S_DIVI;
          end else begin
            degen_r <= 1'b0;
            state_r <= S_M3;
          end
        end
        S_M3: begin
          r1_r    <= R_W'(sy_r) * R_W'(den_r);
          state_r <= S_M4;
        end
        S_M4: begin
          r2_r    <= R_W'(num_r) * R_W'($signed({1'b0, sx_r}));
          nd_r    <= DVS_W'(count_r) * DVS_W'(den_r[DEN_W-2:0]);
          state_r <= S_M5;
        end
        S_M5: begin
          inum_r  <= r1_r - r2_r;
          state_r <= S_DIVS;
        end
        S_DIVS: begin
          state_r <= S_WAITS;
        end
        S_WAITS: begin
          if (div_done) begin
            slope_r <= sat_slope(num_r[NUM_W-1], div_quo);
            state_r <= S_DIVI;
          end
        end
        S_DIVI: begin
          state_r <= S_WAITI;
        end
        S_WAITI: begin
          if (div_done) begin
            slope_out_r <= slope_r;
            icpt_out_r  <= sat_icpt(degen_r ? sy_r[SY_W-1] : inum_r[R_W-1], div_quo);
            pts_out_r   <= count_r;
            stat_out_r  <= degen_r ? ST_DEGEN : ST_FITTED;
            out_valid_r <= 1'b1;
            count_r     <= '0;
            turns_r     <= '0;
            ph_prev_r   <= '0;
            sx_r        <= '0;
            sxx_r       <= '0;
            sy_r        <= '0;
            sxy_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fit_slope     = slope_out_r;
  assign out_fit_intercept = icpt_out_r;
  assign out_points_used   = pts_out_r;
  assign out_fit_status    = stat_out_r;

endmodule

@@ rtl/phase_unwrap_line_fit.sv @@
// A word that is not last leaves the queue in the cycle after it is
// accepted when the back end is free; a last word gives its result after
// fit setup and the serial divisions (slope, then intercept; only the
// intercept for a degenerate frame), or at setup end if it has too few
// points. The four-word queue, and then busy, absorbs the frame end.
// Reset (synchronous, rst_n low) empties the queue and clears all sums.
module phase_unwrap_line_fit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [pul_pkg::IDX_W-1:0]           in_subcarrier_index,
  input  logic signed [pul_pkg::PH_W-1:0]     in_phase_sample,
  input  logic                                in_sample_valid,
  input  logic                                in_last_sample,
  output logic                                out_valid,
  output logic signed [pul_pkg::SLOPE_W-1:0]  out_fit_slope,
  output logic signed [pul_pkg::ICPT_W-1:0]   out_fit_intercept,
  output logic [pul_pkg::CNT_W-1:0]           out_points_used,
  output logic [pul_pkg::STAT_W-1:0]          out_fit_status
);
  import pul_pkg::*;

  // The front end classifies each word (kept or skipped, with the point
  // budget of the frame applied) and queues it. The back end unwraps and
  // accumulates kept words, each word passing through S_IDLE and S_ACC, and
  // on the last word of a frame with enough points forms the least-squares
  // slope and intercept with one shared serial divider, one quotient bit per
  // cycle. The receiver cannot stall: out_valid is a one-cycle strobe.
  logic             pop;
  logic             q_valid;
  item_t            q_head;
  div_req_t         div_req;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;

  pul_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_subcarrier_index (in_subcarrier_index),
    .in_phase_sample     (in_phase_sample),
    .in_sample_valid     (in_sample_valid),
    .in_last_sample      (in_last_sample),
    .pop                 (pop),
    .q_valid             (q_valid),
    .q_head              (q_head)
  );

  pul_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .pop               (pop),
    .div_req           (div_req),
    .div_done          (div_done),
    .div_quo           (div_quo),
    .out_valid         (out_valid),
    .out_fit_slope     (out_fit_slope),
    .out_fit_intercept (out_fit_intercept),
    .out_points_used   (out_points_used),
    .out_fit_status    (out_fit_status)
  );

  pul_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule
